// ===== rtl/u8st_pkg.sv =====
// ----------------------------------------------------------------------------
// u8st_pkg: shared types and constants for the UTF-8 sanitiser
// Byte classes, sequence bounds, the byte limit and the result record.
// ----------------------------------------------------------------------------
package u8st_pkg;

  // Destination size including the terminator; the usable limit is one less.
  localparam int unsigned CAPACITY = 1024;

  localparam int unsigned CNT_W = 10;
  localparam int unsigned CAP_M1 = CAPACITY - 1;
  localparam logic [CNT_W-1:0] LIM_CAP =
      (CAP_M1 > 1023) ? 10'd1023 : CNT_W'(CAP_M1);

  localparam logic [9:0] MAX_BYTES_RST = 10'd640;

  localparam logic [7:0] QMARK      = 8'h3F;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] ASCII_TOP  = 8'h80;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_E0   = 8'hE0;
  localparam logic [7:0] LEAD3_ED   = 8'hED;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD4_F0   = 8'hF0;
  localparam logic [7:0] LEAD4_F4   = 8'hF4;
  localparam logic [7:0] TRAIL_LO   = 8'h80;
  localparam logic [7:0] TRAIL_HI   = 8'hBF;
  localparam logic [7:0] E0_TRAIL_LO = 8'hA0;
  localparam logic [7:0] ED_TRAIL_HI = 8'h9F;
  localparam logic [7:0] F0_TRAIL_LO = 8'h90;
  localparam logic [7:0] F4_TRAIL_HI = 8'h8F;

  // Verdict on the bytes at the head of the scan buffer.
  typedef struct packed {
    logic       invalid;   // lead cannot start a valid sequence
    logic       more;      // prefix fine so far, bytes still missing
    logic [2:0] len;       // sequence length once complete
  } cls_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       last;
    logic       complete;
  } out_item_t;

endpackage

// ===== rtl/u8st_classify.sv =====
// ----------------------------------------------------------------------------
// u8st_classify: strict UTF-8 sequence checker
// Judges the sequence at the head of up to four buffered bytes.
// ----------------------------------------------------------------------------
module u8st_classify (
  input  logic [3:0][7:0]     buf_i,
  input  logic [2:0]          n_i,
  output u8st_pkg::cls_t      cls_o
);

  logic [7:0] b0, b1, b2, b3;
  logic [7:0] lo, hi;
  logic [2:0] need;
  logic       bad;
  logic       inval;

  always_comb begin
    b0 = buf_i[0];
    b1 = buf_i[1];
    b2 = buf_i[2];
    b3 = buf_i[3];
    need = 3'd1;
    lo = u8st_pkg::TRAIL_LO;
    hi = u8st_pkg::TRAIL_HI;
    bad = 1'b0;
    if (b0 < u8st_pkg::ASCII_TOP) begin
      need = 3'd1;
    end else if (b0 >= u8st_pkg::LEAD2_LO && b0 <= u8st_pkg::LEAD2_HI) begin
      need = 3'd2;
    end else if (b0 == u8st_pkg::LEAD3_E0) begin
      need = 3'd3;
      lo = u8st_pkg::E0_TRAIL_LO;
    end else if (b0 == u8st_pkg::LEAD3_ED) begin
      need = 3'd3;
      hi = u8st_pkg::ED_TRAIL_HI;
    end else if (b0 > u8st_pkg::LEAD3_E0 && b0 <= u8st_pkg::LEAD3_HI) begin
      need = 3'd3;
    end else if (b0 == u8st_pkg::LEAD4_F0) begin
      need = 3'd4;
      lo = u8st_pkg::F0_TRAIL_LO;
    end else if (b0 > u8st_pkg::LEAD4_F0 && b0 < u8st_pkg::LEAD4_F4) begin
      need = 3'd4;
    end else if (b0 == u8st_pkg::LEAD4_F4) begin
      need = 3'd4;
      hi = u8st_pkg::F4_TRAIL_HI;
    end else begin
      bad = 1'b1;
    end

    inval = bad
        || (need > 3'd1 && n_i >= 3'd2 && (b1 < lo || b1 > hi))
        || (need > 3'd2 && n_i >= 3'd3
            && (b2 & u8st_pkg::CONT_MASK) != u8st_pkg::CONT_TAG)
        || (need > 3'd3 && n_i >= 3'd4
            && (b3 & u8st_pkg::CONT_MASK) != u8st_pkg::CONT_TAG);

    cls_o.invalid = inval;
    cls_o.more    = !inval && (n_i < need);
    cls_o.len     = need;
  end

endmodule

// ===== rtl/u8st_out_reg.sv =====
// ----------------------------------------------------------------------------
// u8st_out_reg: result output register
// Hold one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module u8st_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  u8st_pkg::out_item_t   item_i,
  output logic                  can_push_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output u8st_pkg::out_item_t   item_o
);

  logic                vld_q;
  u8st_pkg::out_item_t item_q;

  assign can_push_o = !vld_q || m_tready_i;
  assign m_tvalid_o = vld_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (push_i) begin
      vld_q <= 1'b1;
    end else if (m_tready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== rtl/utf8_sanitize_truncate.sv =====
// ----------------------------------------------------------------------------
// utf8_sanitize_truncate: strict UTF-8 sanitiser with an output byte limit
// Pass valid sequences, replace bad leads by '?', stop at the byte limit.
// ----------------------------------------------------------------------------
// Flow: an item is accepted, then scanned: one scan step per '?' or valid
//   sequence and one emit step per byte passed on, then a closing scan and a
//   step that closes the item. Input is held off meanwhile; the single shared
//   checker serves every decision and the output port takes one result per
//   cycle unless the output is stalled.
// Reset: asynchronous, active low; clears sequencer, counters and flags.
module utf8_sanitize_truncate (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // in_last
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic [1:0]  m_tuser,   // [0] out_valid, [1] out_complete
  output logic        m_tlast,   // out_last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam int unsigned CW = u8st_pkg::CNT_W;

  logic [1:0]      state_q, state_d;
  logic [3:0][7:0] buf_q, buf_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [2:0]      rem_q, rem_d;
  logic [CW-1:0]   written_q, written_d;
  logic            stopped_q, stopped_d;
  logic            ended_q, ended_d;
  logic            end_q, end_d;
  logic [7:0]      stg_byte_q, stg_byte_d;
  logic            stg_vld_q, stg_vld_d;
  logic [9:0]      max_bytes_q;

  logic [CW-1:0]   lim;
  logic [CW:0]     sum_len;
  logic            push;
  logic            can_push;
  u8st_pkg::out_item_t push_item;
  u8st_pkg::out_item_t out_item;
  u8st_pkg::cls_t  cls;
  logic            s_acc;
  logic            cfg_wr;

  // --------------------------------------------------------------------------
  // Configuration port: one register, seen at every address with paddr[2] low.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {22'd0, max_bytes_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= u8st_pkg::MAX_BYTES_RST;
    end else if (cfg_wr) begin
      max_bytes_q <= pwdata[9:0];
    end
  end

  // Effective limit: the register clipped to what the destination holds.
  assign lim = (max_bytes_q > u8st_pkg::LIM_CAP) ? u8st_pkg::LIM_CAP : max_bytes_q;

  // --------------------------------------------------------------------------
  // Shared sequence checker, applied to the scan buffer once per decision.
  // --------------------------------------------------------------------------
  u8st_classify u_classify (
    .buf_i (buf_q),
    .n_i   (cnt_q),
    .cls_o (cls)
  );

  assign sum_len  = {1'b0, written_q} + {{(CW-2){1'b0}}, cls.len};
  assign s_tready = (state_q == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;

  // --------------------------------------------------------------------------
  // Sequencer. A byte goes into the scan buffer, then each unstalled cycle
  // decides one head sequence or emits one byte of it. Emitted bytes pass
  // through a one-entry staging slot so a step's final byte can carry last.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    buf_d      = buf_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    written_d  = written_q;
    stopped_d  = stopped_q;
    ended_d    = ended_q;
    end_d      = end_q;
    stg_byte_d = stg_byte_q;
    stg_vld_d  = stg_vld_q;
    push       = 1'b0;
    push_item  = '{data: stg_byte_q, vld: 1'b1, last: 1'b0, complete: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          // start a fresh string after an ending item
          if (ended_q) begin
            cnt_d     = 3'd0;
            written_d = '0;
            stopped_d = 1'b0;
            ended_d   = 1'b0;
          end
          if (!stopped_d && s_tdata != 8'd0) begin
            buf_d[cnt_d[1:0]] = s_tdata;
            cnt_d = cnt_d + 3'd1;
          end
          end_d   = (s_tdata == 8'd0) || s_tlast;
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (stopped_q || cnt_q == 3'd0) begin
          state_d = ST_FINISH;
        end else if (cls.more && !end_q) begin
          // keep the partial sequence for the next byte
          state_d = ST_FINISH;
        end else if (cls.invalid || cls.more) begin
          if (written_q >= lim) begin
            stopped_d = 1'b1;
            state_d   = ST_FINISH;
          end else if (can_push) begin
            // replace the bad lead, rescan the bytes behind it
            push       = stg_vld_q;
            stg_byte_d = u8st_pkg::QMARK;
            stg_vld_d  = 1'b1;
            buf_d      = {8'd0, buf_q[3:1]};
            cnt_d      = cnt_q - 3'd1;
            written_d  = written_q + CW'(1);
          end
        end else if (sum_len > {1'b0, lim}) begin
          stopped_d = 1'b1;
          state_d   = ST_FINISH;
        end else begin
          rem_d   = cls.len;
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (can_push) begin
          push       = stg_vld_q;
          stg_byte_d = buf_q[0];
          stg_vld_d  = 1'b1;
          buf_d      = {8'd0, buf_q[3:1]};
          cnt_d      = cnt_q - 3'd1;
          written_d  = written_q + CW'(1);
          rem_d      = rem_q - 3'd1;
          if (rem_q == 3'd1) begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_FINISH: begin
        if (end_q) begin
          // close the string: staged byte or an empty marker carries last
          if (can_push) begin
            push      = 1'b1;
            push_item = '{data:     stg_vld_q ? stg_byte_q : 8'd0,
                          vld:      stg_vld_q,
                          last:     1'b1,
                          complete: !stopped_q};
            stg_vld_d = 1'b0;
            ended_d   = 1'b1;
            if (stopped_q) cnt_d = 3'd0;
            state_d   = ST_IDLE;
          end
        end else if (!stg_vld_q || can_push) begin
          push      = stg_vld_q;
          stg_vld_d = 1'b0;
          if (stopped_q) cnt_d = 3'd0;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= 3'd0;
      rem_q     <= 3'd0;
      written_q <= '0;
      stopped_q <= 1'b0;
      ended_q   <= 1'b0;
      end_q     <= 1'b0;
      stg_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rem_q     <= rem_d;
      written_q <= written_d;
      stopped_q <= stopped_d;
      ended_q   <= ended_d;
      end_q     <= end_d;
      stg_vld_q <= stg_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q      <= buf_d;
    stg_byte_q <= stg_byte_d;
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  u8st_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (push_item),
    .can_push_o (can_push),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .item_o     (out_item)
  );

  assign m_tdata = out_item.data;
  assign m_tuser = {out_item.complete, out_item.vld};
  assign m_tlast = out_item.last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("scan buffer count above four");

  a_idle_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q <= 3'd3))
    else $error("more than three bytes pending between items");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> can_push)
    else $error("result pushed into a full output register");

  a_stop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && stopped_q) |-> (cnt_q == 3'd0))
    else $error("bytes held after the limit was hit");

  a_emit_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (rem_q != 3'd0 && cnt_q >= rem_q))
    else $error("emit count out of step with the scan buffer");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for the UTF-8 sanitiser with a byte limit
// Drives byte strings through the input stream, predicts every result with a
// behavioural sanitiser kept in step with the accepted transactions, and
// compares each result transaction field by field. The byte limit is set over
// the APB port between phases and read back.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_ITEMS  = 140;
  localparam int unsigned PHASE_ITEMS   = 40;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam logic [2:0]  ADDR_MAX_BYTES = 3'd0;

  // Verdicts on the bytes at the head of the scan window.
  localparam int SEQ_MORE = -1;
  localparam int SEQ_BAD  = 0;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] in_byte
  logic        s_tlast  = 1'b0; // in_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [7:0] out_byte
  logic [1:0]  m_tuser;         // [0] out_valid, [1] out_complete
  logic        m_tlast;         // out_last
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  utf8_sanitize_truncate u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor state: a mirror of the sanitiser, advanced once per accepted
  // input transaction.
  // --------------------------------------------------------------------------
  logic [23:0] held_win   = '0;   // undecided bytes, oldest in the low byte
  int          held_cnt   = 0;
  logic [9:0]  out_count  = '0;   // bytes passed on for the current string
  bit          cut_off    = 1'b0; // limit reached, discard the rest
  bit          str_closed = 1'b0; // previous transaction ended a string
  logic [9:0]  byte_limit = u8st_pkg::MAX_BYTES_RST;

  u8st_pkg::out_item_t clean_q[$]; // sanitised results still to arrive

  // Knobs shared between the stimulus and the two stream processes.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_len   = 0;

  int n_items    = 0;
  int n_strings  = 0;
  int n_results  = 0;
  int n_errors   = 0;
  int n_limits   = 0;
  int n_cycles   = 0;

  // Judge the first n bytes of the window: length of a whole valid sequence,
  // SEQ_BAD if the lead is already broken, SEQ_MORE if bytes are missing.
  function automatic int judge_seq(input logic [31:0] win, input int n);
    logic [7:0] lead, lo, hi;
    int         need, i;
    lead = win[7:0];
    lo   = u8st_pkg::TRAIL_LO;
    hi   = u8st_pkg::TRAIL_HI;
    if (lead < u8st_pkg::ASCII_TOP) return 1;
    if (lead >= u8st_pkg::LEAD2_LO && lead <= u8st_pkg::LEAD2_HI) need = 2;
    else if (lead == u8st_pkg::LEAD3_E0) begin
      need = 3;
      lo   = u8st_pkg::E0_TRAIL_LO;   // reject overlong three-byte forms
    end else if (lead == u8st_pkg::LEAD3_ED) begin
      need = 3;
      hi   = u8st_pkg::ED_TRAIL_HI;   // reject surrogates
    end else if (lead > u8st_pkg::LEAD3_E0 && lead <= u8st_pkg::LEAD3_HI) need = 3;
    else if (lead == u8st_pkg::LEAD4_F0) begin
      need = 4;
      lo   = u8st_pkg::F0_TRAIL_LO;   // reject overlong four-byte forms
    end else if (lead > u8st_pkg::LEAD4_F0 && lead < u8st_pkg::LEAD4_F4) need = 4;
    else if (lead == u8st_pkg::LEAD4_F4) begin
      need = 4;
      hi   = u8st_pkg::F4_TRAIL_HI;   // nothing above U+10FFFF
    end else return SEQ_BAD;
    if (n >= 2 && (win[15:8] < lo || win[15:8] > hi)) return SEQ_BAD;
    for (i = 2; i < need && i < n; i++)
      if ((win[8*i +: 8] & u8st_pkg::CONT_MASK) != u8st_pkg::CONT_TAG) return SEQ_BAD;
    if (n < need) return SEQ_MORE;
    return need;
  endfunction

  // Advance the mirror by one input byte and queue the results it causes.
  function automatic void sanitise_step(input logic [7:0] b, input logic lst);
    logic [31:0]         win;
    int                  n, r, take, lim, emitted, i;
    bit                  fin;
    u8st_pkg::out_item_t rec;
    fin = (b == 8'h00) || lst;
    if (str_closed) begin
      held_win   = '0;
      held_cnt   = 0;
      out_count  = '0;
      cut_off    = 1'b0;
      str_closed = 1'b0;
    end
    lim = int'(byte_limit);
    if (lim > int'(u8st_pkg::CAPACITY) - 1) lim = int'(u8st_pkg::CAPACITY) - 1;
    win     = {8'h00, held_win};
    n       = held_cnt;
    emitted = 0;
    if (!cut_off && b != 8'h00) begin
      win[8*n +: 8] = b;
      n++;
    end
    while (n > 0 && !cut_off) begin
      r = judge_seq(win, n);
      if (r == SEQ_MORE) begin
        if (!fin) break;
        r = SEQ_BAD;            // string ended mid-sequence: the lead is bad
      end
      if (r == SEQ_BAD) begin
        if (int'(out_count) >= lim) begin
          cut_off = 1'b1;
          break;
        end
        take         = 1;
        rec          = '0;
        rec.data     = u8st_pkg::QMARK;
        rec.vld      = 1'b1;
        clean_q.push_back(rec);
        emitted++;
      end else begin
        take = r;
        if (int'(out_count) + take > lim) begin
          cut_off = 1'b1;
          break;
        end
        for (i = 0; i < take; i++) begin
          rec      = '0;
          rec.data = win[8*i +: 8];
          rec.vld  = 1'b1;
          clean_q.push_back(rec);
          emitted++;
        end
      end
      out_count = out_count + 10'(take);
      win       = win >> (8 * take);
      n         = n - take;
    end
    if (cut_off) n = 0;
    held_cnt = n;
    held_win = '0;
    for (i = 0; i < n; i++) held_win[8*i +: 8] = win[8*i +: 8];
    if (fin) begin
      // Mark the last byte of this step, or add an empty closing result.
      if (emitted == 0) rec = '0;
      else rec = clean_q.pop_back();
      rec.last     = 1'b1;
      rec.complete = !cut_off;
      clean_q.push_back(rec);
      str_closed = 1'b1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input side: offer one byte after a random gap, hold it until accepted.
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lst;
    do @(posedge clk_i); while (!s_tready);
    sanitise_step(b, lst);
    n_items++;
    if (b == 8'h00 || lst) n_strings++;
  endtask

  // Drop the input, wait for every pending result, then let the block settle
  // in case it is still chewing on bytes that produce nothing.
  task automatic drain_results;
    s_tvalid <= 1'b0;
    while (clean_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write max_bytes, then read it back.
  task automatic set_byte_limit(input logic [9:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MAX_BYTES;
    pwdata  <= {22'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    byte_limit = v;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {22'b0, v}) begin
      $display("%0t: max_bytes read-back mismatch: expected %08h, got %08h",
               $time, {22'b0, v}, prdata);
      n_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    n_limits++;
  endtask

  // One string of mostly well-formed UTF-8; noise_pct sets how often
  // sequences are bent, cut short or overwritten with a random byte.
  task automatic send_random_string(input int noise_pct);
    logic [7:0] sq[$];
    logic [7:0] lead, second;
    int         n_chars, c, k, ending;
    n_chars = $urandom_range(1, 10);
    for (c = 0; c < n_chars; c++) begin
      case ($urandom_range(0, 3))
        0: sq.push_back(8'($urandom_range(1, 127)));
        1: begin
          sq.push_back(8'($urandom_range(int'(u8st_pkg::LEAD2_LO),
                                         int'(u8st_pkg::LEAD2_HI))));
          sq.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        2: begin
          lead = 8'($urandom_range(int'(u8st_pkg::LEAD3_E0), int'(u8st_pkg::LEAD3_HI)));
          if (lead == u8st_pkg::LEAD3_E0)
            second = 8'($urandom_range(u8st_pkg::E0_TRAIL_LO, u8st_pkg::TRAIL_HI));
          else if (lead == u8st_pkg::LEAD3_ED)
            second = 8'($urandom_range(u8st_pkg::TRAIL_LO, u8st_pkg::ED_TRAIL_HI));
          else
            second = 8'($urandom_range(u8st_pkg::TRAIL_LO, u8st_pkg::TRAIL_HI));
          // near misses: overlong and surrogate second bytes
          if ($urandom_range(0, 99) < noise_pct)
            second = 8'($urandom_range(u8st_pkg::TRAIL_LO, u8st_pkg::TRAIL_HI));
          sq.push_back(lead);
          sq.push_back(second);
          sq.push_back(8'($urandom_range(u8st_pkg::TRAIL_LO, u8st_pkg::TRAIL_HI)));
        end
        default: begin
          lead = 8'($urandom_range(int'(u8st_pkg::LEAD4_F0), int'(u8st_pkg::LEAD4_F4)));
          if (lead == u8st_pkg::LEAD4_F0)
            second = 8'($urandom_range(u8st_pkg::F0_TRAIL_LO, u8st_pkg::TRAIL_HI));
          else if (lead == u8st_pkg::LEAD4_F4)
            second = 8'($urandom_range(u8st_pkg::TRAIL_LO, u8st_pkg::F4_TRAIL_HI));
          else
            second = 8'($urandom_range(u8st_pkg::TRAIL_LO, u8st_pkg::TRAIL_HI));
          if ($urandom_range(0, 99) < noise_pct)
            second = 8'($urandom_range(u8st_pkg::TRAIL_LO, u8st_pkg::TRAIL_HI));
          sq.push_back(lead);
          sq.push_back(second);
          sq.push_back(8'($urandom_range(u8st_pkg::TRAIL_LO, u8st_pkg::TRAIL_HI)));
          sq.push_back(8'($urandom_range(u8st_pkg::TRAIL_LO, u8st_pkg::TRAIL_HI)));
        end
      endcase
      if ($urandom_range(0, 99) < noise_pct) void'(sq.pop_back());
    end
    for (k = 0; k < sq.size(); k++)
      if ($urandom_range(0, 199) < noise_pct) sq[k] = 8'($urandom_range(0, 255));
    ending = (sq.size() == 0) ? 0 : $urandom_range(0, 2);
    for (k = 0; k < sq.size(); k++)
      push_byte(sq[k], (ending == 2) && (k == sq.size() - 1));
    if (ending != 2) push_byte(8'h00, ending == 1);
  endtask

  // --------------------------------------------------------------------------
  // Output side: stall at random before each result, plus one long hold-off
  // counted here when the pressure test asks for it.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall, k;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_len > 0) begin
        m_tready <= 1'b0;
        for (k = 0; k < hold_len; k++) @(posedge clk_i);
        hold_len = 0;
      end
      stall = rx_idle_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  // Compare every accepted result with the oldest prediction; fields are
  // shown as byte/valid/last/complete.
  always @(posedge clk_i) begin : result_check
    u8st_pkg::out_item_t got, want;
    if (rst_ni && m_tvalid && m_tready) begin
      got.data     = m_tdata;
      got.vld      = m_tuser[0];
      got.last     = m_tlast;
      got.complete = m_tuser[1];
      n_results++;
      if (clean_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %02h/%0b/%0b/%0b",
                 $time, got.data, got.vld, got.last, got.complete);
        n_errors++;
      end else begin
        want = clean_q.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                   $time, want.data, want.vld, want.last, want.complete,
                   got.data, got.vld, got.last, got.complete);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: a hung block or a lost result ends the run here.
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("utf8_sanitize_truncate regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Lowest and highest ASCII, lone bytes that cannot lead, a closing zero
  // with nothing left to pass on, and a two-byte form closed by tlast.
  task automatic test_field_extremes;
    push_byte(8'h01, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hC2, 1'b0);
    push_byte(8'h80, 1'b1);
  endtask

  // Strict second-byte bounds: overlong E0, surrogate ED, top F4 and
  // lowest F0; the first two are judged bad as soon as the second byte lands.
  task automatic test_strict_bounds;
    push_byte(8'hE0, 1'b0);
    push_byte(8'h9F, 1'b0);
    push_byte(8'hED, 1'b0);
    push_byte(8'hA0, 1'b0);
    push_byte(8'hF4, 1'b0);
    push_byte(8'h8F, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h90, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b1);
  endtask

  // String closes mid-sequence on a zero byte with tlast also set: the held
  // lead turns into '?' and the trailing byte is scanned again.
  task automatic test_unfinished_tail;
    push_byte(8'hF1, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b1);
  endtask

  // Cut a three-byte sequence at a limit of 3, discard the rest, then check
  // the zero limit with an empty and a non-empty string.
  task automatic test_byte_limit;
    drain_results();
    set_byte_limit(10'd3);
    push_byte(8'h41, 1'b0);
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b0);
    push_byte(8'hAC, 1'b0);
    push_byte(8'h42, 1'b0);
    push_byte(8'h43, 1'b1);
    drain_results();
    set_byte_limit(10'd0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h41, 1'b1);
    drain_results();
  endtask

  // Hold the output off for a long stretch while a back-to-back string is
  // offered, so the block fills up and stalls its input.
  task automatic test_output_hold;
    int k;
    set_byte_limit(10'd1023);
    tx_idle_on = 1'b0;
    hold_len   = HOLD_CYCLES;
    for (k = 0; k < 48; k++) push_byte(8'($urandom_range(1, 127)), 1'b0);
    push_byte(8'($urandom_range(1, 127)), 1'b1);
    drain_results();
    tx_idle_on = 1'b1;
  endtask

  // Random strings in phases, each with its own limit and idling mix.
  task automatic test_random_strings;
    int base, phase, phase_start;
    base  = n_items;
    phase = 0;
    while (n_items - base < RANDOM_ITEMS) begin
      drain_results();
      if (phase == 0) set_byte_limit(10'd1023);
      else begin
        case ($urandom_range(0, 4))
          0:       set_byte_limit(10'd0);
          1:       set_byte_limit(10'd1023);
          2, 3:    set_byte_limit(10'($urandom_range(1, 24)));
          default: set_byte_limit(10'($urandom_range(25, 1022)));
        endcase
      end
      // every few phases run one side or the other flat out
      tx_idle_on  = (phase % 3) != 2;
      rx_idle_on  = (phase % 4) != 3;
      phase_start = n_items;
      while (n_items - phase_start < PHASE_ITEMS)
        send_random_string(($urandom_range(0, 4) == 0) ? 60 : 10);
      phase++;
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_strict_bounds();
    test_unfinished_tail();
    test_byte_limit();
    test_output_hold();
    test_random_strings();

    drain_results();
    $display("Run covered %0d input bytes in %0d strings, %0d results, %0d limit writes.",
             n_items, n_strings, n_results, n_limits);
    $display("Included strict lead bounds, rescans, limit cut-off and a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("utf8_sanitize_truncate regression: pass");
    end else begin
      $display("utf8_sanitize_truncate regression: fail");
    end
    $finish;
  end

endmodule

// ===== utf8_sanitize_truncate.f =====
rtl/u8st_pkg.sv
rtl/u8st_classify.sv
rtl/u8st_out_reg.sv
rtl/utf8_sanitize_truncate.sv
test/tb.sv
